### design/ifo_pkg.sv
// shared types, constants and ramp functions of the instance fade opacity block
package ifo_pkg;

	localparam int TagW     = 10;
	localparam int OpW      = 13;
	localparam int AddrW    = 5;
	localparam int DataW    = 32;
	localparam int DivBits  = 16;
	localparam int DivSteps = 2;
	localparam int DivStages = DivBits / DivSteps;
	localparam int SqInW    = 52;
	localparam int SqW      = 53;
	localparam int SqRootW  = 26;
	localparam int SqSteps  = 2;
	localparam int SqStages = SqRootW / SqSteps;

	localparam logic [OpW-1:0] One       = 13'd4096;
	localparam logic [OpW-1:0] OpaqueMin = 13'd4092;

	localparam logic [2:0] RegRider   = 3'd0;
	localparam logic [2:0] RegCamX    = 3'd1;
	localparam logic [2:0] RegCamZ    = 3'd2;
	localparam logic [2:0] RegTgtX    = 3'd3;
	localparam logic [2:0] RegTgtZ    = 3'd4;
	localparam logic [2:0] RegTree    = 3'd5;
	localparam logic [2:0] RegPass    = 3'd6;
	localparam logic [2:0] RegReady   = 3'd7;

	localparam logic [1:0] PassCombined = 2'd0;
	localparam logic [1:0] PassOpaque   = 2'd1;
	localparam logic [1:0] PassFading   = 2'd2;

	typedef struct packed {
		logic signed [31:0] rider;
		logic signed [23:0] cam_x;
		logic signed [23:0] cam_z;
		logic signed [23:0] tgt_x;
		logic signed [23:0] tgt_z;
		logic               tree;
		logic [1:0]         pass;
		logic               ready;
	} cfg_t;

	// per-item data that rides along the pipeline
	typedef struct packed {
		logic [TagW-1:0]    tag;
		logic [OpW-1:0]     edge_op;
		logic [15:0]        radius;
		logic signed [24:0] dx;
		logic signed [24:0] dz;
	} ctx_t;

	// clamped ramp num << sh
	function automatic logic [OpW-1:0] ramp_shift(input logic signed [33:0] num,
		input logic [1:0] sh);
		logic [33:0] lim;
		logic [33:0] v;
		lim = 34'(One) >> sh;
		v   = 34'(num) << sh;
		if (num <= 34'sd0) return '0;
		else if (num >= $signed(lim)) return One;
		else return v[OpW-1:0];
	endfunction

	// clamped ramp num * 8 / 3
	function automatic logic [OpW-1:0] ramp_tree_behind(input logic signed [33:0] num);
		logic [13:0] x;
		logic [30:0] p;
		x = {num[10:0], 3'b000};
		p = 31'(x) * 31'd43691;
		if (num <= 34'sd0) return '0;
		else if (num >= 34'sd1536) return One;
		else return p[29:17];
	endfunction

	// clamped ramp c * 64 / 5
	function automatic logic [OpW-1:0] ramp_tree_cam(input logic signed [27:0] c);
		logic [14:0] x;
		logic [31:0] p;
		x = {c[8:0], 6'b000000};
		p = 32'(x) * 32'd52429;
		if (c <= 28'sd0) return '0;
		else if (c >= 28'sd320) return One;
		else return p[30:18];
	endfunction

	// clamped ramp c * 160 / 9
	function automatic logic [OpW-1:0] ramp_bush_cam(input logic signed [27:0] c);
		logic [15:0] x;
		logic [31:0] p;
		x = 16'(c[7:0]) * 16'd160;
		p = 32'(x) * 32'd58255;
		if (c <= 28'sd0) return '0;
		else if (c >= 28'sd231) return One;
		else return p[31:19];
	endfunction

endpackage

### design/ifo_cfg.sv
// configuration registers behind the apb port
module ifo_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ifo_pkg::AddrW-1:0] paddr,
	input  logic [ifo_pkg::DataW-1:0] pwdata,
	output logic [ifo_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output ifo_pkg::cfg_t             cfg
);
	import ifo_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[AddrW-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= '0;
			cfg_q.tree  <= 1'b1;
		end else if (wr) begin
			unique case (idx)
				RegRider: cfg_q.rider <= pwdata;
				RegCamX:  cfg_q.cam_x <= pwdata[23:0];
				RegCamZ:  cfg_q.cam_z <= pwdata[23:0];
				RegTgtX:  cfg_q.tgt_x <= pwdata[23:0];
				RegTgtZ:  cfg_q.tgt_z <= pwdata[23:0];
				RegTree:  cfg_q.tree  <= pwdata[0];
				RegPass:  cfg_q.pass  <= pwdata[1:0];
				RegReady: cfg_q.ready <= pwdata[0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			RegRider: prdata = cfg_q.rider;
			RegCamX:  prdata = {8'd0, cfg_q.cam_x};
			RegCamZ:  prdata = {8'd0, cfg_q.cam_z};
			RegTgtX:  prdata = {8'd0, cfg_q.tgt_x};
			RegTgtZ:  prdata = {8'd0, cfg_q.tgt_z};
			RegTree:  prdata = {31'd0, cfg_q.tree};
			RegPass:  prdata = {30'd0, cfg_q.pass};
			RegReady: prdata = {31'd0, cfg_q.ready};
			default:  prdata = '0;
		endcase
	end

endmodule

### design/ifo_div.sv
// pipelined restoring divider for the segment blend, two quotient bits per stage
module ifo_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  ifo_pkg::ctx_t       ctx_in,
	input  logic [49:0]         rem_in,
	input  logic [49:0]         len_in,
	input  logic                zero_in,
	input  logic                one_in,
	output logic                vld_out,
	output ifo_pkg::ctx_t       ctx_out,
	output logic [16:0]         blend
);
	import ifo_pkg::*;

	logic                vld_s  [DivStages];
	ctx_t                ctx_s  [DivStages];
	logic [49:0]         rem_s  [DivStages];
	logic [49:0]         len_s  [DivStages];
	logic [DivBits-1:0]  quo_s  [DivStages];
	logic                zero_s [DivStages];
	logic                one_s  [DivStages];

	for (genvar g = 0; g < DivStages; g++) begin : g_stage
		logic               v_i;
		ctx_t               c_i;
		logic [49:0]        r_i;
		logic [49:0]        l_i;
		logic [DivBits-1:0] q_i;
		logic               z_i;
		logic               o_i;
		logic [49:0]        r_n;
		logic [DivBits-1:0] q_n;

		if (g == 0) begin : g_first
			assign v_i = vld_in;
			assign c_i = ctx_in;
			assign r_i = rem_in;
			assign l_i = len_in;
			assign q_i = '0;
			assign z_i = zero_in;
			assign o_i = one_in;
		end else begin : g_next
			assign v_i = vld_s[g-1];
			assign c_i = ctx_s[g-1];
			assign r_i = rem_s[g-1];
			assign l_i = len_s[g-1];
			assign q_i = quo_s[g-1];
			assign z_i = zero_s[g-1];
			assign o_i = one_s[g-1];
		end

		always_comb begin
			logic [50:0] t;
			r_n = r_i;
			q_n = q_i;
			for (int i = 0; i < DivSteps; i++) begin
				t = {r_n, 1'b0};
				if (t >= {1'b0, l_i}) begin
					t   = t - {1'b0, l_i};
					q_n = {q_n[DivBits-2:0], 1'b1};
				end else begin
					q_n = {q_n[DivBits-2:0], 1'b0};
				end
				r_n = t[49:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[g]  <= c_i;
				rem_s[g]  <= r_n;
				len_s[g]  <= l_i;
				quo_s[g]  <= q_n;
				zero_s[g] <= z_i;
				one_s[g]  <= o_i;
			end
		end
	end

	assign vld_out = vld_s[DivStages-1];
	assign ctx_out = ctx_s[DivStages-1];

	always_comb begin
		if (zero_s[DivStages-1]) blend = '0;
		else if (one_s[DivStages-1]) blend = 17'h10000;
		else blend = {1'b0, quo_s[DivStages-1]};
	end

endmodule

### design/ifo_isqrt.sv
// pipelined digit-by-digit integer square root, two result bits per stage
module ifo_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_in,
	input  ifo_pkg::ctx_t               ctx_in,
	input  logic [ifo_pkg::SqInW-1:0]   rad_in,
	output logic                        vld_out,
	output ifo_pkg::ctx_t               ctx_out,
	output logic [ifo_pkg::SqRootW-1:0] root
);
	import ifo_pkg::*;

	logic           vld_s [SqStages];
	ctx_t           ctx_s [SqStages];
	logic [SqW-1:0] val_s [SqStages];
	logic [SqW-1:0] res_s [SqStages];

	for (genvar g = 0; g < SqStages; g++) begin : g_stage
		logic           v_i;
		ctx_t           c_i;
		logic [SqW-1:0] a_i;
		logic [SqW-1:0] r_i;
		logic [SqW-1:0] a_n;
		logic [SqW-1:0] r_n;

		if (g == 0) begin : g_first
			assign v_i = vld_in;
			assign c_i = ctx_in;
			assign a_i = SqW'(rad_in);
			assign r_i = '0;
		end else begin : g_next
			assign v_i = vld_s[g-1];
			assign c_i = ctx_s[g-1];
			assign a_i = val_s[g-1];
			assign r_i = res_s[g-1];
		end

		always_comb begin
			logic [SqW-1:0] b;
			logic [SqW-1:0] t;
			a_n = a_i;
			r_n = r_i;
			for (int i = 0; i < SqSteps; i++) begin
				b = SqW'(1) << (2 * (SqRootW - 1 - (g * SqSteps + i)));
				t = r_n + b;
				if (a_n >= t) begin
					a_n = a_n - t;
					r_n = (r_n >> 1) + b;
				end else begin
					r_n = r_n >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[g] <= c_i;
				val_s[g] <= a_n;
				res_s[g] <= r_n;
			end
		end
	end

	assign vld_out = vld_s[SqStages-1];
	assign ctx_out = ctx_s[SqStages-1];
	assign root    = res_s[SqStages-1][SqRootW-1:0];

endmodule

### design/instance_fade_opacity.sv
// Fade opacity per scene placement. One item is accepted per clock unless the output
// stalls; items pass the 8-stage blend divider and the 13-stage square root of the
// camera clearance. A stalled output freezes the whole pipeline. The user must write
// configuration over APB at byte address 4*i while no item is in flight; the block
// does not enforce this. Opacity and alpha are Q1.12 with 4096 as fully opaque.
module instance_fade_opacity (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ifo_pkg::AddrW-1:0]   paddr,
	input  logic [ifo_pkg::DataW-1:0]   pwdata,
	output logic [ifo_pkg::DataW-1:0]   prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ifo_pkg::TagW-1:0]    placement_index,
	input  logic signed [31:0]          placement_distance,
	input  logic signed [23:0]          pos_x,
	input  logic signed [23:0]          pos_z,
	input  logic [15:0]                 crown_radius,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ifo_pkg::TagW-1:0]    tag_out,
	output logic [ifo_pkg::OpW-1:0]     opacity,
	output logic                        include_res,
	output logic [ifo_pkg::OpW-1:0]     colour_alpha
);
	import ifo_pkg::*;

	cfg_t               cfg;
	logic               en;
	logic signed [24:0] sx;
	logic signed [24:0] sz;

	ifo_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign sx = {cfg.tgt_x[23], cfg.tgt_x} - {cfg.cam_x[23], cfg.cam_x};
	assign sz = {cfg.tgt_z[23], cfg.tgt_z} - {cfg.cam_z[23], cfg.cam_z};

	// stage 1: offsets
	logic               vld_s1;
	logic [TagW-1:0]    tag_s1;
	logic signed [32:0] rel_s1;
	logic signed [24:0] dx_s1;
	logic signed [24:0] dz_s1;
	logic [15:0]        rad_s1;

	// stage 2: products and edge fade
	logic               vld_s2;
	ctx_t               ctx_s2;
	logic signed [49:0] pxs_s2;
	logic signed [49:0] pzs_s2;
	logic signed [49:0] lxx_s2;
	logic signed [49:0] lzz_s2;

	// stage 3: dot and squared length
	logic               vld_s3;
	ctx_t               ctx_s3;
	logic [49:0]        rem_s3;
	logic [49:0]        len_s3;
	logic               zero_s3;
	logic               one_s3;

	logic               vld_div;
	ctx_t               ctx_div;
	logic [16:0]        blend;

	// stages 12 to 15: nearest point offset and squared clearance
	logic               vld_s12;
	ctx_t               ctx_s12;
	logic signed [42:0] pbx_s12;
	logic signed [42:0] pbz_s12;
	logic               vld_s13;
	ctx_t               ctx_s13;
	logic signed [26:0] ex_s13;
	logic signed [26:0] ez_s13;
	logic               vld_s14;
	ctx_t               ctx_s14;
	logic [50:0]        exx_s14;
	logic [50:0]        ezz_s14;
	logic               vld_s15;
	ctx_t               ctx_s15;
	logic [SqInW-1:0]   sum_s15;

	logic               vld_sq;
	ctx_t               ctx_sq;
	logic [SqRootW-1:0] clear;

	// stage 29: output register
	logic               vld_s29;
	logic [TagW-1:0]    tag_s29;
	logic [OpW-1:0]     op_s29;
	logic               inc_s29;
	logic [OpW-1:0]     alpha_s29;

	assign in_stall = vld_s29 && out_stall;
	assign en       = !in_stall;

	// edge fade
	logic signed [33:0] rel34;
	logic [OpW-1:0]     behind;
	logic [OpW-1:0]     ahead;
	logic [OpW-1:0]     edge_n;

	always_comb begin
		rel34 = {rel_s1[32], rel_s1};
		if (cfg.tree) begin
			behind = ramp_tree_behind(rel34 + 34'sd4864);
			ahead  = ramp_shift(34'sd8704 - rel34, 2'd1);
		end else begin
			behind = ramp_shift(rel34 + 34'sd3584, 2'd2);
			ahead  = ramp_shift(34'sd11264 - rel34, 2'd1);
		end
		edge_n = (behind < ahead) ? behind : ahead;
	end

	// blend cases
	logic signed [50:0] dot;
	logic [49:0]        len2;
	logic               zero_n;

	always_comb begin
		dot    = {pxs_s2[49], pxs_s2} + {pzs_s2[49], pzs_s2};
		len2   = {1'b0, lxx_s2[48:0]} + {1'b0, lzz_s2[48:0]};
		zero_n = (len2 == '0) || (dot <= 51'sd0);
	end

	logic [53:0] exx_n;
	logic [53:0] ezz_n;
	assign exx_n = 54'(ex_s13 * ex_s13);
	assign ezz_n = 54'(ez_s13 * ez_s13);

	// camera fade and pass selection
	logic signed [27:0] cam_c;
	logic [OpW-1:0]     cam_op;
	logic [OpW-1:0]     op_n;
	logic               opaque;
	logic               inc_n;
	logic [OpW-1:0]     alpha_n;

	always_comb begin
		if (cfg.tree) begin
			cam_c  = $signed({2'b00, clear}) - $signed({12'd0, ctx_sq.radius}) - 28'sd218;
			cam_op = ramp_tree_cam(cam_c);
		end else begin
			cam_c  = $signed({2'b00, clear}) - 28'sd141;
			cam_op = ramp_bush_cam(cam_c);
		end
		if (cfg.ready) op_n = (ctx_sq.edge_op < cam_op) ? ctx_sq.edge_op : cam_op;
		else op_n = One;
		opaque = op_n >= OpaqueMin;
		case (cfg.pass)
			PassOpaque: inc_n = opaque;
			PassFading: inc_n = !opaque;
			default:    inc_n = 1'b1;
		endcase
		if (!inc_n) alpha_n = '0;
		else if (cfg.pass == PassOpaque) alpha_n = One;
		else alpha_n = op_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s29 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s12 <= vld_div;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s29 <= vld_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1  <= placement_index;
			rel_s1  <= {placement_distance[31], placement_distance}
				- {cfg.rider[31], cfg.rider};
			dx_s1   <= {pos_x[23], pos_x} - {cfg.cam_x[23], cfg.cam_x};
			dz_s1   <= {pos_z[23], pos_z} - {cfg.cam_z[23], cfg.cam_z};
			rad_s1  <= crown_radius;

			ctx_s2.tag     <= tag_s1;
			ctx_s2.edge_op <= edge_n;
			ctx_s2.radius  <= rad_s1;
			ctx_s2.dx      <= dx_s1;
			ctx_s2.dz      <= dz_s1;
			pxs_s2 <= dx_s1 * sx;
			pzs_s2 <= dz_s1 * sz;
			lxx_s2 <= sx * sx;
			lzz_s2 <= sz * sz;

			ctx_s3  <= ctx_s2;
			rem_s3  <= dot[49:0];
			len_s3  <= len2;
			zero_s3 <= zero_n;
			one_s3  <= !zero_n && (dot >= $signed({1'b0, len2}));

			ctx_s12 <= ctx_div;
			pbx_s12 <= $signed({1'b0, blend}) * sx;
			pbz_s12 <= $signed({1'b0, blend}) * sz;

			ctx_s13 <= ctx_s12;
			ex_s13  <= {{2{ctx_s12.dx[24]}}, ctx_s12.dx} - pbx_s12[42:16];
			ez_s13  <= {{2{ctx_s12.dz[24]}}, ctx_s12.dz} - pbz_s12[42:16];

			ctx_s14 <= ctx_s13;
			exx_s14 <= exx_n[50:0];
			ezz_s14 <= ezz_n[50:0];

			ctx_s15 <= ctx_s14;
			sum_s15 <= SqInW'(exx_s14) + SqInW'(ezz_s14);

			tag_s29   <= ctx_sq.tag;
			op_s29    <= op_n;
			inc_s29   <= inc_n;
			alpha_s29 <= alpha_n;
		end
	end

	ifo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_in (vld_s3),
		.ctx_in (ctx_s3),
		.rem_in (rem_s3),
		.len_in (len_s3),
		.zero_in(zero_s3),
		.one_in (one_s3),
		.vld_out(vld_div),
		.ctx_out(ctx_div),
		.blend  (blend)
	);

	ifo_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_in (vld_s15),
		.ctx_in (ctx_s15),
		.rad_in (sum_s15),
		.vld_out(vld_sq),
		.ctx_out(ctx_sq),
		.root   (clear)
	);

	assign out_valid    = vld_s29;
	assign tag_out      = tag_s29;
	assign opacity      = op_s29;
	assign include_res  = inc_s29;
	assign colour_alpha = alpha_s29;

endmodule

### design/ifo_check.sv
// port-level checks of the instance fade opacity block
module ifo_check (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [ifo_pkg::OpW-1:0]  opacity,
	input logic                     include_res,
	input logic [ifo_pkg::OpW-1:0]  colour_alpha
);
	import ifo_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> opacity <= One)
		else $error("opacity above one");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !include_res |-> colour_alpha == '0)
		else $error("excluded item has nonzero alpha");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && include_res && colour_alpha != One |-> colour_alpha == opacity)
		else $error("alpha differs from opacity");

endmodule

bind instance_fade_opacity ifo_check u_ifo_check (.*);

### tb/sv/tb_top.sv
// testbench for the instance fade opacity block: table walk, random items, scoreboard
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ifo_pkg::*;

	localparam int PipeLat = 29;
	localparam int WatchLimit = 2000;
	localparam int RandItems = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [TagW-1:0] placement_index = '0;
	logic signed [31:0] placement_distance = '0;
	logic signed [23:0] pos_x = '0, pos_z = '0;
	logic [15:0] crown_radius = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [TagW-1:0] tag_out;
	logic [OpW-1:0] opacity, colour_alpha;
	logic include_res;

	instance_fade_opacity dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic [TagW-1:0] tag;
		logic [OpW-1:0]  op;
		logic            incl;
		logic [OpW-1:0]  alpha;
	} fade_res_t;

	typedef struct {
		logic [TagW-1:0]    tag;
		logic signed [31:0] route_d;
		logic signed [23:0] x;
		logic signed [23:0] z;
		logic [15:0]        rad;
		bit                 known;
		fade_res_t          res;
	} row_t;

	cfg_t cfg;
	fade_res_t pending_fades[$];
	row_t dir_rows[$];
	int errors = 0;
	int watch = 0;
	bit quiet = 1'b0;
	bit rx_idle_on = 1'b1;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	function automatic longint clamp_ramp(longint num, longint mul, longint dv);
		longint v;
		if (num <= 0) return 0;
		v = num * mul / dv;
		return v > 4096 ? 4096 : v;
	endfunction

	function automatic longint shr16_floor(longint v);
		if (v >= 0) return v >>> 16;
		return -((-v + 65535) >>> 16);
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic fade_res_t predict_fade(logic [TagW-1:0] tag, logic signed [31:0] route_d,
		logic signed [23:0] x, logic signed [23:0] z, logic [15:0] rad);
		fade_res_t r;
		longint rel, eb, ea, ef, sx, sz, dx, dz, len2, dotp, blend, ex, ez, clr, cf, op;
		longint rr, qq;
		bit opq, incl;
		op = 4096;
		if (cfg.ready) begin
			rel = longint'(route_d) - longint'(cfg.rider);
			if (cfg.tree) begin
				eb = clamp_ramp(rel + 4864, 8, 3);
				ea = clamp_ramp(8704 - rel, 2, 1);
			end else begin
				eb = clamp_ramp(rel + 3584, 4, 1);
				ea = clamp_ramp(11264 - rel, 2, 1);
			end
			ef = eb < ea ? eb : ea;
			sx = longint'(cfg.tgt_x) - longint'(cfg.cam_x);
			sz = longint'(cfg.tgt_z) - longint'(cfg.cam_z);
			dx = longint'(x) - longint'(cfg.cam_x);
			dz = longint'(z) - longint'(cfg.cam_z);
			len2 = sx * sx + sz * sz;
			dotp = dx * sx + dz * sz;
			blend = 0;
			if (len2 > 0 && dotp > 0) begin
				if (dotp >= len2) blend = 65536;
				else begin
					// long division bit by bit, dot << 16 does not fit 64 bits
					rr = dotp;
					qq = 0;
					for (int i = 0; i < 16; i++) begin
						rr = rr << 1;
						qq = qq << 1;
						if (rr >= len2) begin
							rr -= len2;
							qq |= 1;
						end
					end
					blend = qq;
				end
			end
			ex = dx - shr16_floor(blend * sx);
			ez = dz - shr16_floor(blend * sz);
			clr = root_floor(longint'(ex * ex) + longint'(ez * ez));
			if (cfg.tree) cf = clamp_ramp(clr - longint'(rad) - 218, 64, 5);
			else cf = clamp_ramp(clr - 141, 160, 9);
			op = ef < cf ? ef : cf;
		end
		opq = op >= 4092;
		if (cfg.pass == PassOpaque) incl = opq;
		else if (cfg.pass == PassFading) incl = !opq;
		else incl = 1'b1;
		r.tag = tag;
		r.op = OpW'(op);
		r.incl = incl;
		if (!incl) r.alpha = '0;
		else if (cfg.pass == PassOpaque) r.alpha = One;
		else r.alpha = OpW'(op);
		return r;
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= AddrW'({idx, 2'b00}); pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			RegRider: cfg.rider = val;
			RegCamX:  cfg.cam_x = val[23:0];
			RegCamZ:  cfg.cam_z = val[23:0];
			RegTgtX:  cfg.tgt_x = val[23:0];
			RegTgtZ:  cfg.tgt_z = val[23:0];
			RegTree:  cfg.tree = val[0];
			RegPass:  cfg.pass = val[1:0];
			RegReady: cfg.ready = val[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_fades.size() != 0) @(posedge clk);
		repeat (PipeLat + 4) @(posedge clk);
	endtask

	// sender: one item, optional idle burst before it, held until accepted
	task automatic send_item(input row_t r);
		fade_res_t e;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end else @(negedge clk);
		in_valid <= 1'b1;
		placement_index <= r.tag; placement_distance <= r.route_d;
		pos_x <= r.x; pos_z <= r.z; crown_radius <= r.rad;
		e = predict_fade(r.tag, r.route_d, r.x, r.z, r.rad);
		if (r.known && e != r.res) report("table row vs predictor, tag", r.tag, e.tag);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_fades.insert(pending_fades.size(), e);
	endtask

	task automatic end_items();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic row_t rand_row();
		row_t r;
		int k;
		r.tag = TagW'($urandom);
		r.rad = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 600));
		r.known = 1'b0;
		k = $urandom_range(0, 9);
		if (k == 0) begin
			r.route_d = $urandom; r.x = $urandom; r.z = $urandom;
		end else begin
			// near the rider and the camera segment so ramps are exercised
			r.route_d = cfg.rider + $signed(32'($urandom_range(0, 16000))) - 32'sd5000;
			r.x = cfg.cam_x + $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
			r.z = cfg.cam_z + $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
		end
		return r;
	endfunction

	task automatic rand_config(input bit extreme);
		if (extreme) begin
			reg_write(RegRider, $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
			reg_write(RegCamX, $urandom_range(0, 1) ? 32'h7fffff : 32'h800000);
			reg_write(RegCamZ, $urandom_range(0, 1) ? 32'h7fffff : 32'h800000);
			reg_write(RegTgtX, $urandom_range(0, 1) ? 32'h7fffff : 32'h800000);
			reg_write(RegTgtZ, $urandom_range(0, 1) ? 32'h7fffff : 32'h800000);
		end else begin
			reg_write(RegRider, $urandom);
			reg_write(RegCamX, $urandom);
			reg_write(RegCamZ, $urandom);
			reg_write(RegTgtX, 32'(cfg.cam_x + $signed(24'($urandom_range(0, 8000))) - 24'sd4000));
			reg_write(RegTgtZ, 32'(cfg.cam_z + $signed(24'($urandom_range(0, 8000))) - 24'sd4000));
		end
		reg_write(RegTree, $urandom_range(0, 1));
		reg_write(RegPass, $urandom_range(0, 3));
		reg_write(RegReady, $urandom_range(0, 4) != 0);
	endtask

	// receiver: random stall bursts, check at rising edge
	always @(negedge clk) begin
		if (rx_idle_on && !quiet && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 9)) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		fade_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fades.size() == 0) begin
				report("unexpected item, tag_out", tag_out, 0);
			end else begin
				e = pending_fades.pop_front();
				if (tag_out !== e.tag) report("tag_out", tag_out, e.tag);
				if (opacity !== e.op) report("opacity", opacity, e.op);
				if (include_res !== e.incl) report("include_res", include_res, e.incl);
				if (colour_alpha !== e.alpha) report("colour_alpha", colour_alpha, e.alpha);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) watch <= 0;
		else watch <= watch + 1;
		if (watch >= WatchLimit) begin
			$display("** instance_fade_opacity: FAILED **");
			$finish;
		end
	end

	function automatic row_t mk(logic [TagW-1:0] t, logic signed [31:0] d, logic signed [23:0] x,
		logic signed [23:0] z, logic [15:0] rd, bit kn, fade_res_t res);
		row_t r;
		r.tag = t; r.route_d = d; r.x = x; r.z = z; r.rad = rd; r.known = kn; r.res = res;
		return r;
	endfunction

	function automatic void add_row(row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// send every queued table row, then let the pipeline drain
	task automatic walk_rows();
		foreach (dir_rows[i]) send_item(dir_rows[i]);
		dir_rows.delete();
		end_items();
		wait_drained();
	endtask

	initial begin
		int n;
		cfg = '{rider: 0, cam_x: 0, cam_z: 0, tgt_x: 0, tgt_z: 0, tree: 1'b1,
			pass: PassCombined, ready: 1'b0};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// after reset: not ready gives full opacity
		add_row(mk(10'd0, 32'sh80000000, 24'sh800000, 24'sh800000, 16'h0, 1'b1,
			'{10'd0, One, 1'b1, One}));
		add_row(mk(10'h3ff, 32'sh7fffffff, 24'sh7fffff, 24'sh7fffff, 16'hffff, 1'b1,
			'{10'h3ff, One, 1'b1, One}));
		walk_rows();
		// ready with degenerate segment: camera at origin equals target
		reg_write(RegReady, 1);
		add_row(mk(10'd1, 32'sh0, 24'sh0, 24'sh0, 16'h0, 1'b1, '{10'd1, 13'd0, 1'b1, 13'd0}));
		add_row(mk(10'd2, 32'sh7fffffff, 24'sd5000, 24'sd0, 16'h0, 1'b1,
			'{10'd2, 13'd0, 1'b1, 13'd0}));
		add_row(mk(10'd3, 32'sd2000, 24'sd5000, 24'sd5000, 16'd0, 1'b0, '{default: 0}));
		add_row(mk(10'd4, 32'sd0, 24'sd400, 24'sd0, 16'd100, 1'b0, '{default: 0}));
		add_row(mk(10'd5, -32'sd4000, 24'sh7fffff, 24'sh800000, 16'hffff, 1'b0, '{default: 0}));
		walk_rows();
		reg_write(RegTgtX, 32'd2560);
		reg_write(RegTgtZ, 32'hfffff600);
		reg_write(RegTree, 0);
		add_row(mk(10'd6, 32'sd1000, 24'sd1280, 24'sd600, 16'd0, 1'b0, '{default: 0}));
		add_row(mk(10'd7, 32'sd1000, 24'sd5000, -24'sd5000, 16'd0, 1'b0, '{default: 0}));
		add_row(mk(10'd8, -32'sd3584, 24'sd0, 24'sd900, 16'd0, 1'b0, '{default: 0}));
		walk_rows();
		// opaque, fading and unused pass codes
		for (int p = 1; p <= 3; p++) begin
			reg_write(RegPass, p);
			add_row(mk(10'd9, 32'sd1000, 24'sd0, 24'sd3000, 16'd0, 1'b0, '{default: 0}));
			add_row(mk(10'd10, 32'sd0, 24'sd0, 24'sd0, 16'd0, 1'b0, '{default: 0}));
			add_row(mk(10'd11, 32'sd11000, 24'sd0, 24'sd3000, 16'd0, 1'b0, '{default: 0}));
			walk_rows();
		end

		// random phases
		n = 0;
		for (int ph = 0; ph < 10; ph++) begin
			rand_config(ph == 3 || ph == 7);
			if (ph == 9) quiet = 1'b1;
			for (int i = 0; i < RandItems / 10; i++) begin
				send_item(rand_row());
				n++;
				// hold-off until everything expected has come
				if (ph == 4 && i == 50) begin
					end_items();
					while (pending_fades.size() != 0) @(posedge clk);
				end
			end
			end_items();
			wait_drained();
		end

		if (errors == 0) $display("** instance_fade_opacity: PASSED **");
		else $display("** instance_fade_opacity: FAILED **");
		$finish;
	end
endmodule

### sim.f
design/ifo_pkg.sv
design/ifo_cfg.sv
design/ifo_div.sv
design/ifo_isqrt.sv
design/instance_fade_opacity.sv
design/ifo_check.sv
tb/sv/tb_top.sv
